/* hdl/piecewise_linear_interp_table_assert.svh */
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table_assert.svh
// assertion macros shared by the interpolation table checker
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_ASSERT_SVH

// same-cycle implication
`define PLI_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pli assertion failed");

// next-cycle implication
`define PLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pli assertion failed");

`endif

/* hdl/pli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// types and constants of the piecewise linear interpolation table
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int DW              = 16;
    localparam int PROD_W          = 34;
    localparam int DIV_STEPS       = 34;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LOW  = 2'd1,
        ST_HIGH = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RDI,
        S_SORT_GETI,
        S_SORT_RDK,
        S_SORT_CMP,
        S_SORT_WRI,
        S_Q_RD,
        S_Q_CHK,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_FIN,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
    } entry_t;

endpackage

/* hdl/pli_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/piecewise_linear_interp_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table
// breakpoint table with lazy sort, linear search and serial divide
// ----------------------------------------------------------------------------
// Clear, load and unused commands are answered directly from idle. A query
// scans the table entries one by one, and when it interpolates it also runs
// the 34-step one-bit-per-cycle divider. The first query after a load
// first sorts the table through the breakpoint ram, reading and comparing
// one entry per step. The block handles one command at a time and holds
// s_ready low while it works.
module piecewise_linear_interp_table #(
    parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic signed [pli_pkg::DW-1:0]     s_x_value,
    input  logic signed [pli_pkg::DW-1:0]     s_y_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pli_pkg::DW-1:0]     m_result_y,
    output logic [1:0]                        m_status
);
    import pli_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fsm_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic sorted_reg, sorted_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    entry_t cur_reg, cur_next;
    entry_t prev_reg, prev_next;
    logic signed [DW-1:0] qx_reg, qx_next;
    logic signed [DW:0] dx_reg, dx_next;
    logic signed [DW:0] dy_reg, dy_next;
    logic [DW-1:0] den_reg, den_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic neg_reg, neg_next;
    logic [PROD_W-1:0] div_reg, div_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [5:0] cnt_reg, cnt_next;
    logic signed [DW-1:0] pres_reg, pres_next;
    status_t pstat_reg, pstat_next;
    logic m_valid_reg, m_valid_next;
    logic signed [DW-1:0] res_reg, res_next;
    status_t stat_reg, stat_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t ram_wdata, ram_rdata;

    logic out_free, in_beat;
    cmd_t cmd;
    logic [DW:0] trial;
    logic signed [PROD_W:0] quot;
    logic signed [PROD_W+1:0] sum;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign in_beat  = s_valid && s_ready;
    assign cmd      = cmd_t'(s_command);
    assign trial    = {rem_reg, div_reg[PROD_W-1]};
    assign quot     = neg_reg ? -$signed({1'b0, div_reg}) : $signed({1'b0, div_reg});
    assign sum      = (PROD_W+2)'(quot) + (PROD_W+2)'(prev_reg.y);

    pli_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat && cmd == CMD_QUERY && count_reg != '0) begin
                    if (!sorted_reg && count_reg > CW'(1)) begin
                        state_next = S_SORT_RDI;
                    end else begin
                        state_next = S_Q_RD;
                    end
                end
            end
            S_SORT_RDI:  state_next = S_SORT_GETI;
            S_SORT_GETI: state_next = S_SORT_RDK;
            S_SORT_RDK:  state_next = S_SORT_CMP;
            S_SORT_CMP: begin
                if (CW'(k_reg + 1'b1) == count_reg) begin
                    state_next = S_SORT_WRI;
                end else begin
                    state_next = S_SORT_RDK;
                end
            end
            S_SORT_WRI: begin
                if (({1'b0, i_reg} + (CW+1)'(2)) == {1'b0, count_reg}) begin
                    state_next = S_Q_RD;
                end else begin
                    state_next = S_SORT_RDI;
                end
            end
            S_Q_RD: state_next = S_Q_CHK;
            S_Q_CHK: begin
                if (ram_rdata.x == qx_reg) begin
                    state_next = S_OUT;
                end else if (ram_rdata.x > qx_reg) begin
                    state_next = (i_reg == '0) ? S_OUT : S_MUL;
                end else if (CW'(i_reg + 1'b1) == count_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_Q_RD;
                end
            end
            S_MUL:      state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = S_DIV;
            S_DIV: begin
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next   = count_reg;
        sorted_next  = sorted_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        qx_next      = qx_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        den_next     = den_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        pres_next    = pres_reg;
        pstat_next   = pstat_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = cur_reg;
        ram_raddr    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    qx_next = s_x_value;
                    i_next  = '0;
                    unique case (cmd)
                        CMD_CLEAR: begin
                            count_next   = '0;
                            sorted_next  = 1'b1;
                            m_valid_next = 1'b1;
                            res_next     = '0;
                            stat_next    = ST_OK;
                        end
                        CMD_LOAD: begin
                            m_valid_next = 1'b1;
                            res_next     = '0;
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                stat_next = ST_FULL;
                            end else begin
                                stat_next   = ST_OK;
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[AW-1:0];
                                ram_wdata   = '{x: s_x_value, y: s_y_value};
                                count_next  = CW'(count_reg + 1'b1);
                                sorted_next = 1'b0;
                            end
                        end
                        CMD_QUERY: begin
                            sorted_next = 1'b1;
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                res_next     = '0;
                                stat_next    = ST_LOW;
                            end
                        end
                        CMD_NONE: begin
                            m_valid_next = 1'b1;
                            res_next     = '0;
                            stat_next    = ST_OK;
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT_RDI: ram_raddr = i_reg[AW-1:0];
            S_SORT_GETI: begin
                cur_next = ram_rdata;
                k_next   = CW'(i_reg + 1'b1);
            end
            S_SORT_RDK: ram_raddr = k_reg[AW-1:0];
            S_SORT_CMP: begin
                if (cur_reg.x > ram_rdata.x) begin
                    ram_we    = 1'b1;
                    ram_waddr = k_reg[AW-1:0];
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
                k_next = CW'(k_reg + 1'b1);
            end
            S_SORT_WRI: begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[AW-1:0];
                ram_wdata = cur_reg;
                if (({1'b0, i_reg} + (CW+1)'(2)) == {1'b0, count_reg}) begin
                    i_next = '0;
                end else begin
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            S_Q_RD: ram_raddr = i_reg[AW-1:0];
            S_Q_CHK: begin
                pres_next = '0;
                if (ram_rdata.x == qx_reg) begin
                    pres_next  = ram_rdata.y;
                    pstat_next = ST_OK;
                end else if (ram_rdata.x > qx_reg) begin
                    pstat_next = ST_LOW;
                    dx_next    = (DW+1)'(qx_reg) - (DW+1)'(prev_reg.x);
                    dy_next    = (DW+1)'(ram_rdata.y) - (DW+1)'(prev_reg.y);
                    den_next   = DW'(ram_rdata.x - prev_reg.x);
                end else begin
                    prev_next  = ram_rdata;
                    pstat_next = (count_reg == CW'(1)) ? ST_LOW : ST_HIGH;
                    i_next     = CW'(i_reg + 1'b1);
                end
            end
            S_MUL: prod_next = PROD_W'(dx_reg * dy_reg);
            S_DIV_INIT: begin
                neg_next = prod_reg[PROD_W-1];
                div_next = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
                rem_next = '0;
                cnt_next = '0;
            end
            S_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = DW'(trial - {1'b0, den_reg});
                    div_next = {div_reg[PROD_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DW-1:0];
                    div_next = {div_reg[PROD_W-2:0], 1'b0};
                end
                cnt_next = 6'(cnt_reg + 1'b1);
            end
            S_FIN: begin
                pstat_next = ST_OK;
                if (sum > (PROD_W+2)'(32767)) begin
                    pres_next = 16'sh7fff;
                end else if (sum < -(PROD_W+2)'(32768)) begin
                    pres_next = 16'sh8000;
                end else begin
                    pres_next = sum[DW-1:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    res_next     = pres_reg;
                    stat_next    = pstat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sorted_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sorted_reg  <= sorted_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg     <= i_next;
        k_reg     <= k_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        qx_reg    <= qx_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        den_reg   <= den_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        pres_reg  <= pres_next;
        pstat_reg <= pstat_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_result_y = res_reg;
    assign m_status   = stat_reg;

endmodule

/* hdl/pli_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_checker
// port-level checks of the interpolation table, bound to the top level
// ----------------------------------------------------------------------------
`include "piecewise_linear_interp_table_assert.svh"

module pli_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_command,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [pli_pkg::DW-1:0] m_result_y,
    input logic [1:0]                    m_status
);
    import pli_pkg::*;

    // a pending result beat is held
    `PLI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // no new command while a result is stuck
    `PLI_ASSERT_SAME(a_busy_out, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // failed commands report zero
    `PLI_ASSERT_SAME(a_zero_res, aclk, aresetn, m_valid && m_status != ST_OK, m_result_y == '0)
    // clear answers in the next cycle
    `PLI_ASSERT_NEXT(a_clear_done, aclk, aresetn, s_valid && s_ready && s_command == CMD_CLEAR, m_valid && m_status == ST_OK && m_result_y == '0)

endmodule

bind piecewise_linear_interp_table pli_checker u_pli_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_command  (s_command),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_result_y (m_result_y),
    .m_status   (m_status)
);

/* tb/interp_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interp_table_checker
// watches both channels of the interpolation table, keeps a shadow copy of
// the breakpoint table, predicts each result beat and compares it
// ----------------------------------------------------------------------------
module interp_table_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic signed [15:0]            s_x_value,
    input  logic signed [15:0]            s_y_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [15:0]            m_result_y,
    input  logic [1:0]                    m_status,
    output int                            pending_count,
    output int                            fail_count
);
    import pli_pkg::*;

    typedef struct {
        logic signed [15:0] y;
        status_t            st;
    } interp_result_t;

    logic signed [15:0] bp_x [TABLE_DEPTH];
    logic signed [15:0] bp_y [TABLE_DEPTH];
    int                 bp_count;
    bit                 bp_sorted;
    interp_result_t     expected_q [$];

    task automatic sort_breakpoints();
        logic signed [15:0] t;
        for (int i = 0; i + 1 < bp_count; i++) begin
            for (int k = i + 1; k < bp_count; k++) begin
                if (bp_x[i] > bp_x[k]) begin
                    t = bp_x[i]; bp_x[i] = bp_x[k]; bp_x[k] = t;
                    t = bp_y[i]; bp_y[i] = bp_y[k]; bp_y[k] = t;
                end
            end
        end
    endtask

    function automatic interp_result_t lookup_y(logic signed [15:0] xq);
        interp_result_t r;
        longint num, den, sum;
        int i;
        r.y = '0;
        r.st = ST_OK;
        if (bp_count == 0 || (bp_count == 1 && xq != bp_x[0])) begin
            r.st = ST_LOW;
            return r;
        end
        for (i = 0; i < bp_count; i++) begin
            if (bp_x[i] == xq) begin
                r.y = bp_y[i];
                return r;
            end
        end
        if (bp_x[0] > xq) begin
            r.st = ST_LOW;
            return r;
        end
        if (bp_x[bp_count-1] < xq) begin
            r.st = ST_HIGH;
            return r;
        end
        for (i = 1; i < bp_count; i++)
            if (bp_x[i] > xq) break;
        num = (longint'(xq) - longint'(bp_x[i-1])) *
              (longint'(bp_y[i]) - longint'(bp_y[i-1]));
        den = longint'(bp_x[i]) - longint'(bp_x[i-1]);
        sum = num / den + longint'(bp_y[i-1]);
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        r.y = 16'(sum);
        return r;
    endfunction

    always @(posedge aclk) begin
        interp_result_t e;
        if (!aresetn) begin
            bp_count  <= 0;
            bp_sorted <= 1'b1;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                e.y = '0;
                e.st = ST_OK;
                case (cmd_t'(s_command))
                    CMD_CLEAR: begin
                        bp_count = 0;
                        bp_sorted = 1'b1;
                    end
                    CMD_LOAD: begin
                        if (bp_count >= TABLE_DEPTH) begin
                            e.st = ST_FULL;
                        end else begin
                            bp_x[bp_count] = s_x_value;
                            bp_y[bp_count] = s_y_value;
                            bp_count = bp_count + 1;
                            bp_sorted = 1'b0;
                        end
                    end
                    CMD_QUERY: begin
                        if (!bp_sorted) begin
                            sort_breakpoints();
                            bp_sorted = 1'b1;
                        end
                        e = lookup_y(s_x_value);
                        if (e.st != ST_OK) e.y = '0;
                    end
                    default: ;
                endcase
                expected_q.insert(expected_q.size(), e);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with none expected, got y=%0d status=%0d",
                             $time, m_result_y, m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (m_result_y !== e.y || m_status !== e.st) begin
                        $display("%0t: mismatch expected y=%0d status=%0d, actual y=%0d status=%0d",
                                 $time, e.y, e.st, m_result_y, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count = expected_q.size();
    end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives clear, load, query and unused commands into the interpolation
// table with random idle bursts on both sides; the checker predicts and
// compares
module testbench;
    import pli_pkg::*;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_CLEAR;
    logic signed [15:0] s_x_value = '0;
    logic signed [15:0] s_y_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_result_y;
    logic [1:0]         m_status;
    int                 pending_count;
    int                 fail_count;
    int                 idle_cycles = 0;
    int                 beats_sent = 0;
    int                 queries_sent = 0;
    bit                 quiet = 1'b0;

    always #6 aclk = ~aclk;

    piecewise_linear_interp_table #(.TABLE_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_x_value(s_x_value), .s_y_value(s_y_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_y(m_result_y), .m_status(m_status)
    );

    interp_table_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_x_value(s_x_value), .s_y_value(s_y_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_y(m_result_y), .m_status(m_status),
        .pending_count(pending_count), .fail_count(fail_count)
    );

    // result side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (quiet || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_beat(cmd_t cmd, logic signed [15:0] x, logic signed [15:0] y);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_x_value <= x;
        s_y_value <= y;
        do @(posedge aclk); while (!(s_valid && s_ready));
        beats_sent++;
        if (cmd == CMD_QUERY) queries_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        int n;
        logic signed [15:0] base;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, single point, extremes, full table, unused code
        send_beat(CMD_QUERY, 16'sh0000, 16'sh7fff);
        send_beat(CMD_LOAD, 16'sh0100, 16'sh1000);
        send_beat(CMD_QUERY, 16'sh0100, 16'sh0000);
        send_beat(CMD_QUERY, 16'sh0200, 16'sh0000);
        send_beat(CMD_LOAD, 16'sh8000, 16'sh7fff);
        send_beat(CMD_LOAD, 16'sh7fff, 16'sh8000);
        send_beat(CMD_LOAD, 16'sh0100, 16'sh2000);
        send_beat(CMD_QUERY, 16'sh0100, 16'sh0000);
        send_beat(CMD_QUERY, 16'sh8001, 16'sh0000);
        send_beat(CMD_QUERY, 16'sh7ffe, 16'sh0000);
        send_beat(CMD_NONE, 16'shffff, 16'shffff);
        send_beat(CMD_CLEAR, 16'sh1234, 16'sh5678);
        send_beat(CMD_LOAD, 16'sh0000, 16'sh8000);
        send_beat(CMD_LOAD, 16'sh0010, 16'sh7fff);
        send_beat(CMD_QUERY, 16'shffff, 16'sh0000);
        send_beat(CMD_QUERY, 16'sh0011, 16'sh0000);
        send_beat(CMD_QUERY, 16'sh0008, 16'sh0000);
        send_beat(CMD_CLEAR, 16'sh0000, 16'sh0000);
        for (int i = 0; i < DEPTH + 1; i++)
            send_beat(CMD_LOAD, 16'($urandom), 16'($urandom));
        send_beat(CMD_QUERY, 16'($urandom), 16'sh0000);
        wait_drained();

        // random: build small tables, then query inside and around them
        while (beats_sent < 1400) begin
            if (beats_sent > 1200) quiet = 1'b1;
            send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, DEPTH + 2)
                                              : $urandom_range(0, 6);
            base = 16'($urandom);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_beat(CMD_LOAD, 16'($urandom), 16'($urandom));
                else
                    send_beat(CMD_LOAD, base + 16'($urandom_range(0, 2000)) - 16'sd1000,
                              16'($urandom));
                if ($urandom_range(0, 7) == 0)
                    send_beat(CMD_QUERY, base + 16'($urandom_range(0, 2000)) - 16'sd1000,
                              16'($urandom));
            end
            repeat ($urandom_range(2, 8)) begin
                case ($urandom_range(0, 9))
                    0: send_beat(CMD_NONE, 16'($urandom), 16'($urandom));
                    1: send_beat(CMD_QUERY, 16'($urandom), 16'($urandom));
                    default: send_beat(CMD_QUERY,
                                       base + 16'($urandom_range(0, 2400)) - 16'sd1200,
                                       16'($urandom));
                endcase
            end
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        $display("sent %0d command beats, %0d of them queries, on tables of up to %0d points",
                 beats_sent, queries_sent, DEPTH);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
